// File: hdl/cldac_pkg.sv
package cldac_pkg;

  localparam int DAC_BITS = 12;
  localparam logic [DAC_BITS-1:0] CODE_MAX = '1;

  localparam int CODE_LOW  = 718;
  localparam int CODE_HIGH = 3607;
  localparam int CODE_SPAN = CODE_HIGH - CODE_LOW;

  localparam int LEVEL_W = 32;
  localparam int CAL_W   = 15;

  localparam logic [CAL_W-1:0] WIN_LOW_MIN  = 15'd3584;
  localparam logic [CAL_W-1:0] WIN_LOW_MAX  = 15'd4608;
  localparam logic [CAL_W-1:0] WIN_HIGH_MIN = 15'd19456;
  localparam logic [CAL_W-1:0] WIN_HIGH_MAX = 15'd21504;

  // Target current in units of 2^-16 mA.
  localparam int T_FRAC_BITS = 20;
  localparam int TDIV_STAGES = T_FRAC_BITS + 1;
  localparam int T_W         = 21;
  localparam logic [T_W-1:0] T_4MA   = 21'd262144;
  localparam logic [T_W-1:0] T_FAULT = 21'd1474560;

  localparam int DEN_W  = 21;
  localparam int TERM_W = T_W + 1;
  localparam int BASE_W = 31;
  localparam int NUM_W  = 35;
  localparam int CQ_W   = NUM_W - DEN_W;
  localparam int CMP_W  = (CQ_W > DAC_BITS) ? CQ_W : DAC_BITS;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-3:0] REG_RANGE_MIN = 2'd0;
  localparam logic [ADDR_W-3:0] REG_RANGE_MAX = 2'd1;
  localparam logic [ADDR_W-3:0] REG_CAL_LOW   = 2'd2;
  localparam logic [ADDR_W-3:0] REG_CAL_HIGH  = 2'd3;

  typedef struct packed {
    logic [LEVEL_W-1:0] level_value;
    logic               fault_active;
  } sample_t;

  typedef struct packed {
    logic [DAC_BITS-1:0] dac_code;
    logic                cal_valid;
    logic                value_clamped;
    logic                code_saturated;
  } result_t;

  typedef struct packed {
    logic fault;
    logic empty;
    logic clamped;
  } side_t;

endpackage

// File: hdl/cldac_front.sv
module cldac_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  cldac_pkg::sample_t           in_word,
  input  logic [cldac_pkg::LEVEL_W-1:0] range_min,
  input  logic [cldac_pkg::LEVEL_W-1:0] range_max,
  output logic                         valid,
  output logic [cldac_pkg::LEVEL_W-1:0] off,
  output cldac_pkg::side_t             side
);
  import cldac_pkg::*;

  logic               lt;
  logic               gt;
  logic [LEVEL_W-1:0] span_c;
  logic [LEVEL_W-1:0] diff;

  assign lt     = in_word.level_value < range_min;
  assign gt     = in_word.level_value > range_max;
  assign span_c = range_max - range_min;
  assign diff   = in_word.level_value - range_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      off          <= lt ? '0 : (gt ? span_c : diff);
      side.fault   <= in_word.fault_active;
      side.empty   <= range_max <= range_min;
      side.clamped <= lt || gt;
    end
  end

endmodule

// File: hdl/cldac_tdiv.sv
module cldac_tdiv (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [cldac_pkg::LEVEL_W-1:0]  off,
  input  cldac_pkg::side_t               in_side,
  input  logic [cldac_pkg::LEVEL_W-1:0]  span,
  output logic                           out_valid,
  output logic [cldac_pkg::T_FRAC_BITS:0] quo,
  output cldac_pkg::side_t               out_side
);
  import cldac_pkg::*;

  // One quotient bit per stage, most significant first.
  logic [TDIV_STAGES-1:0] v;
  logic [LEVEL_W:0]       rem      [TDIV_STAGES];
  logic [T_FRAC_BITS:0]   quo_s    [TDIV_STAGES];
  side_t                  sd       [TDIV_STAGES];
  logic [LEVEL_W:0]       trial    [TDIV_STAGES];
  logic [T_FRAC_BITS:0]   qprev    [TDIV_STAGES];
  logic                   vprev    [TDIV_STAGES];
  side_t                  sprev    [TDIV_STAGES];
  logic                   ge       [TDIV_STAGES];
  logic [LEVEL_W:0]       rem_next [TDIV_STAGES];

  for (genvar j = 0; j < TDIV_STAGES; j++) begin : g_stage
    if (j == 0) begin : g_first
      assign trial[j] = {1'b0, off};
      assign qprev[j] = '0;
      assign vprev[j] = in_valid;
      assign sprev[j] = in_side;
    end else begin : g_next
      assign trial[j] = {rem[j-1][LEVEL_W-1:0], 1'b0};
      assign qprev[j] = quo_s[j-1];
      assign vprev[j] = v[j-1];
      assign sprev[j] = sd[j-1];
    end

    assign ge[j]       = trial[j] >= {1'b0, span};
    assign rem_next[j] = ge[j] ? (trial[j] - {1'b0, span}) : trial[j];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (en) begin
        v[j] <= vprev[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j]   <= rem_next[j];
        quo_s[j] <= {qprev[j][T_FRAC_BITS-1:0], ge[j]};
        sd[j]    <= sprev[j];
      end
    end
  end

  assign out_valid = v[TDIV_STAGES-1];
  assign quo       = quo_s[TDIV_STAGES-1];
  assign out_side  = sd[TDIV_STAGES-1];

endmodule

// File: hdl/cldac_code.sv
module cldac_code (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [cldac_pkg::T_FRAC_BITS:0] quo,
  input  cldac_pkg::side_t                in_side,
  input  logic [cldac_pkg::T_W-1:0]       i1x64,
  input  logic [cldac_pkg::DEN_W-1:0]     den,
  input  logic [cldac_pkg::BASE_W-1:0]    base,
  input  logic                            cal_ok,
  output logic                            out_valid,
  output cldac_pkg::result_t              out_word
);
  import cldac_pkg::*;

  typedef struct packed {
    logic neg;
    logic clamped;
  } flag_t;

  logic [T_W-1:0]           t_c;
  logic signed [NUM_W-1:0]  prod_c;
  logic signed [NUM_W-1:0]  num_c;

  logic                     a_v;
  logic signed [TERM_W-1:0] a_term;
  logic                     a_clamped;
  logic                     b_v;
  logic signed [NUM_W-1:0]  b_prod;
  logic                     b_clamped;
  logic                     c_v;
  logic signed [NUM_W-1:0]  c_num;
  logic                     c_clamped;

  logic [CQ_W-1:0]  dv;
  logic [DEN_W-1:0] rem      [CQ_W];
  logic [CQ_W-1:0]  low      [CQ_W];
  logic [CQ_W-1:0]  dq       [CQ_W];
  flag_t            fl       [CQ_W];
  logic [DEN_W-1:0] rprev    [CQ_W];
  logic [CQ_W-1:0]  lprev    [CQ_W];
  logic [CQ_W-1:0]  qprev    [CQ_W];
  flag_t            fprev    [CQ_W];
  logic             vprev    [CQ_W];
  logic [DEN_W:0]   trial    [CQ_W];
  logic             ge       [CQ_W];
  logic [DEN_W:0]   rem_next [CQ_W];

  logic [CMP_W-1:0] q_ext;

  always_comb begin
    if (in_side.fault) begin
      t_c = T_FAULT;
    end else if (in_side.empty) begin
      t_c = T_4MA;
    end else begin
      t_c = T_4MA + T_W'(quo);
    end
  end

  assign prod_c = NUM_W'(a_term) * NUM_W'(CODE_SPAN);
  assign num_c  = $signed(NUM_W'(base)) + b_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
    end else if (en) begin
      a_v <= in_valid;
      b_v <= a_v;
      c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_term    <= $signed({1'b0, t_c}) - $signed({1'b0, i1x64});
      a_clamped <= in_side.clamped;
      b_prod    <= prod_c;
      b_clamped <= a_clamped;
      c_num     <= num_c;
      c_clamped <= b_clamped;
    end
  end

  // Long division of the numerator by the calibration slope, one bit per stage.
  for (genvar k = 0; k < CQ_W; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign rprev[k] = c_num[NUM_W-1:CQ_W];
      assign lprev[k] = c_num[CQ_W-1:0];
      assign qprev[k] = '0;
      assign fprev[k] = '{neg: c_num[NUM_W-1], clamped: c_clamped};
      assign vprev[k] = c_v;
    end else begin : g_next
      assign rprev[k] = rem[k-1];
      assign lprev[k] = low[k-1];
      assign qprev[k] = dq[k-1];
      assign fprev[k] = fl[k-1];
      assign vprev[k] = dv[k-1];
    end

    assign trial[k]    = {rprev[k], lprev[k][CQ_W-1]};
    assign ge[k]       = trial[k] >= {1'b0, den};
    assign rem_next[k] = ge[k] ? (trial[k] - {1'b0, den}) : trial[k];

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k] <= 1'b0;
      end else if (en) begin
        dv[k] <= vprev[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= rem_next[k][DEN_W-1:0];
        low[k] <= {lprev[k][CQ_W-2:0], 1'b0};
        dq[k]  <= {qprev[k][CQ_W-2:0], ge[k]};
        fl[k]  <= fprev[k];
      end
    end
  end

  assign q_ext = CMP_W'(dq[CQ_W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[CQ_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word.cal_valid     <= cal_ok;
      out_word.value_clamped <= fl[CQ_W-1].clamped;
      if (!cal_ok) begin
        out_word.dac_code       <= '0;
        out_word.code_saturated <= 1'b0;
      end else if (fl[CQ_W-1].neg) begin
        out_word.dac_code       <= '0;
        out_word.code_saturated <= 1'b1;
      end else if (q_ext > CMP_W'(CODE_MAX)) begin
        out_word.dac_code       <= CODE_MAX;
        out_word.code_saturated <= 1'b1;
      end else begin
        out_word.dac_code       <= DAC_BITS'(q_ext);
        out_word.code_saturated <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/cldac_oreg.sv
module cldac_oreg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  cldac_pkg::result_t in_word,
  input  logic               stall,
  output logic               out_valid,
  output cldac_pkg::result_t out_word,
  output logic               hold
);
  import cldac_pkg::*;

  logic    out_free;
  result_t skid_word;

  assign out_free = !out_valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      hold      <= 1'b0;
    end else if (hold) begin
      if (out_free) begin
        out_valid <= 1'b1;
        hold      <= 1'b0;
      end
    end else if (out_free) begin
      out_valid <= in_valid;
    end else if (in_valid) begin
      hold <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (hold) begin
      if (out_free) begin
        out_word <= skid_word;
      end
    end else if (out_free) begin
      out_word <= in_word;
    end else begin
      skid_word <= in_word;
    end
  end

endmodule

// File: hdl/current_loop_dac_scaler.sv
// Scales a measured level to a 4 to 20 mA loop current (22.5 mA on a fault) and
// turns it into a DAC code through a two-point calibration line. The block takes
// one word per clock while sample_stall is low and returns one result word per
// input word. Two restoring dividers each resolve one quotient bit per pipeline
// stage (21 stages for the target current, 14 for the DAC code). An output
// register with a one-word skid buffer lets one more word enter after the output
// stalls. Registers must be written through the APB port only while no word is in
// flight; the block does not enforce this. Derived slope values are registered.
module current_loop_dac_scaler (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  cldac_pkg::sample_t            sample,
  output logic                          result_valid,
  input  logic                          result_stall,
  output cldac_pkg::result_t            result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cldac_pkg::ADDR_W-1:0]  paddr,
  input  logic [cldac_pkg::DATA_W-1:0]  pwdata,
  output logic [cldac_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);
  import cldac_pkg::*;

  logic [LEVEL_W-1:0] range_min;
  logic [LEVEL_W-1:0] range_max;
  logic [CAL_W-1:0]   cal_low_ma;
  logic [CAL_W-1:0]   cal_high_ma;
  logic [LEVEL_W-1:0] span;
  logic               cal_ok;
  logic [DEN_W-1:0]   den;
  logic [BASE_W-1:0]  base;
  logic [T_W-1:0]     i1x64;

  logic               en;
  logic               hold;
  logic               f_valid;
  logic [LEVEL_W-1:0] f_off;
  side_t              f_side;
  logic               t_valid;
  logic [T_FRAC_BITS:0] t_quo;
  side_t              t_side;
  logic               c_valid;
  result_t            c_word;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_min   <= '0;
      range_max   <= '0;
      cal_low_ma  <= '0;
      cal_high_ma <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[ADDR_W-1:2])
        REG_RANGE_MIN: range_min   <= pwdata;
        REG_RANGE_MAX: range_max   <= pwdata;
        REG_CAL_LOW:   cal_low_ma  <= pwdata[CAL_W-1:0];
        REG_CAL_HIGH:  cal_high_ma <= pwdata[CAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[ADDR_W-1:2])
      REG_RANGE_MIN: prdata = range_min;
      REG_RANGE_MAX: prdata = range_max;
      REG_CAL_LOW:   prdata = DATA_W'(cal_low_ma);
      REG_CAL_HIGH:  prdata = DATA_W'(cal_high_ma);
      default:       prdata = '0;
    endcase
  end

  assign i1x64 = {cal_low_ma, 6'b0};

  always_ff @(posedge clk) begin
    span   <= range_max - range_min;
    den    <= {cal_high_ma - cal_low_ma, 6'b0};
    base   <= BASE_W'(den * CODE_LOW);
    cal_ok <= (cal_low_ma >= WIN_LOW_MIN) && (cal_low_ma <= WIN_LOW_MAX) &&
              (cal_high_ma >= WIN_HIGH_MIN) && (cal_high_ma <= WIN_HIGH_MAX);
  end

  assign en           = !hold;
  assign sample_stall = hold;

  cldac_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sample_valid),
    .in_word   (sample),
    .range_min (range_min),
    .range_max (range_max),
    .valid     (f_valid),
    .off       (f_off),
    .side      (f_side)
  );

  cldac_tdiv u_tdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .off       (f_off),
    .in_side   (f_side),
    .span      (span),
    .out_valid (t_valid),
    .quo       (t_quo),
    .out_side  (t_side)
  );

  cldac_code u_code (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (t_valid),
    .quo       (t_quo),
    .in_side   (t_side),
    .i1x64     (i1x64),
    .den       (den),
    .base      (base),
    .cal_ok    (cal_ok),
    .out_valid (c_valid),
    .out_word  (c_word)
  );

  cldac_oreg u_oreg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_valid),
    .in_word   (c_word),
    .stall     (result_stall),
    .out_valid (result_valid),
    .out_word  (result),
    .hold      (hold)
  );

`ifndef SYNTH
  a_uncal_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.cal_valid |-> !result.code_saturated && result.dac_code == '0)
    else $error("Uncalibrated word carries a nonzero or saturated code.");

  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.code_saturated |-> result.dac_code == '0 ||
    result.dac_code == CODE_MAX)
    else $error("Saturated code is not at either end of the range.");

  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> result_valid)
    else $error("Skid buffer full while the output register is empty.");

  a_hold_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(sample_stall) |-> $past(result_valid && result_stall))
    else $error("Skid buffer filled without a stalled output word.");
`endif

endmodule

// File: dv/tb.sv
module tb;
  import cldac_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PHASES = 6;
  localparam int WORDS_PER_PHASE = 200;

  // Predicts the DAC result of each accepted word and checks results in order.
  class loop_code_board;
    logic [LEVEL_W-1:0] range_lo, range_hi;
    logic [CAL_W-1:0] cal_lo, cal_hi;
    result_t expected_codes[$];
    int errors, checked, n_fault, n_clamped, n_sat, n_uncal;

    function new();
      range_lo = '0;
      range_hi = '0;
      cal_lo = '0;
      cal_hi = '0;
      errors = 0;
      checked = 0;
      n_fault = 0;
      n_clamped = 0;
      n_sat = 0;
      n_uncal = 0;
    endfunction

    function void set_reg(logic [ADDR_W-3:0] idx, logic [DATA_W-1:0] val);
      case (idx)
        REG_RANGE_MIN: range_lo = val;
        REG_RANGE_MAX: range_hi = val;
        REG_CAL_LOW: cal_lo = val[CAL_W-1:0];
        REG_CAL_HIGH: cal_hi = val[CAL_W-1:0];
        default: ;
      endcase
    endfunction

    function result_t scale_to_code(sample_t s);
      longint target, den, num, quot;
      longint unsigned span, off;
      logic [LEVEL_W-1:0] v;
      result_t r;
      r = '0;
      r.value_clamped = (s.level_value < range_lo) || (s.level_value > range_hi);
      r.cal_valid = (cal_lo >= WIN_LOW_MIN) && (cal_lo <= WIN_LOW_MAX) &&
                    (cal_hi >= WIN_HIGH_MIN) && (cal_hi <= WIN_HIGH_MAX);
      if (s.fault_active) begin
        target = longint'(T_FAULT);
      end else if (range_hi <= range_lo) begin
        target = longint'(T_4MA);
      end else begin
        v = s.level_value;
        if (v < range_lo) v = range_lo;
        if (v > range_hi) v = range_hi;
        span = longint'(range_hi) - longint'(range_lo);
        off = longint'(v) - longint'(range_lo);
        target = longint'(T_4MA) + longint'((off << 20) / span);
      end
      if (r.cal_valid) begin
        den = 64 * (longint'(cal_hi) - longint'(cal_lo));
        num = CODE_LOW * den + CODE_SPAN * (target - 64 * longint'(cal_lo));
        if (num < 0) begin
          r.code_saturated = 1'b1;
        end else begin
          quot = num / den;
          if (quot > longint'(CODE_MAX)) begin
            r.dac_code = CODE_MAX;
            r.code_saturated = 1'b1;
          end else begin
            r.dac_code = quot[DAC_BITS-1:0];
          end
        end
      end
      return r;
    endfunction

    function void note_sample(sample_t s);
      if (s.fault_active) n_fault++;
      expected_codes.push_back(scale_to_code(s));
    endfunction

    function void report_field(string what, int exp_val, int got_val);
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_val, got_val);
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (expected_codes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, got %h", $time, got);
        return;
      end
      exp_r = expected_codes.pop_front();
      checked++;
      if (got.value_clamped) n_clamped++;
      if (got.code_saturated) n_sat++;
      if (!got.cal_valid) n_uncal++;
      if (got.dac_code !== exp_r.dac_code)
        report_field("dac_code", exp_r.dac_code, got.dac_code);
      if (got.cal_valid !== exp_r.cal_valid)
        report_field("cal_valid", exp_r.cal_valid, got.cal_valid);
      if (got.value_clamped !== exp_r.value_clamped)
        report_field("value_clamped", exp_r.value_clamped, got.value_clamped);
      if (got.code_saturated !== exp_r.code_saturated)
        report_field("code_saturated", exp_r.code_saturated, got.code_saturated);
    endfunction

    function int pending();
      return expected_codes.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  sample_t sample = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  loop_code_board board = new();
  int src_idle_pct = 20;
  int sink_idle_pct = 20;
  int hold_left = 0;
  bit hold_start = 1'b0;
  int cycles = 0;
  int settings = 1;

  current_loop_dac_scaler uut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample(sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: done, errors");
      $finish;
    end
  end

  // The receiver stalls at random, or for a long stretch when asked.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) board.check_result(result);
    if (hold_start) begin
      hold_left = HOLD_CYCLES;
      hold_start = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  task automatic reg_write(input logic [ADDR_W-3:0] idx, input logic [DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.set_reg(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [31:0] lo, input logic [31:0] hi,
                               input logic [31:0] c_lo, input logic [31:0] c_hi);
    reg_write(REG_RANGE_MIN, lo);
    reg_write(REG_RANGE_MAX, hi);
    reg_write(REG_CAL_LOW, c_lo);
    reg_write(REG_CAL_HIGH, c_hi);
    settings++;
    repeat (4) @(posedge clk);
  endtask

  task automatic send_word(input logic [LEVEL_W-1:0] level, input logic fault);
    if ($urandom_range(99) < src_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    sample <= '{level_value: level, fault_active: fault};
    sample_valid <= 1'b1;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    board.note_sample('{level_value: level, fault_active: fault});
  endtask

  // Stop offering words and wait until every expected result is back.
  task automatic finish_phase();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_level(logic [31:0] lo, logic [31:0] hi);
    logic [63:0] width;
    width = (hi >= lo) ? (64'(hi) - 64'(lo) + 64'd1) : 64'd1;
    case ($urandom_range(9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return lo;
      3: return hi;
      4: return lo - 32'd1;
      5: return hi + 32'd1;
      6, 7: return lo + 32'({$urandom, $urandom} % width);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_setting();
    logic [31:0] lo, hi, tmp;
    logic [CAL_W-1:0] c_lo, c_hi;
    lo = $urandom;
    hi = $urandom;
    case ($urandom_range(9))
      0: hi = lo;
      1: begin
        if (lo == 0) lo = 32'd1;
        hi = $urandom % lo;
      end
      2: begin
        lo = '0;
        hi = '1;
      end
      3, 4, 5: hi = (lo > 32'hFFFF_0000) ? '1 : lo + $urandom_range(5000, 1);
      default: begin
        if (hi < lo) begin
          tmp = lo;
          lo = hi;
          hi = tmp;
        end
      end
    endcase
    c_lo = ($urandom_range(99) < 15) ? CAL_W'($urandom) :
           CAL_W'($urandom_range(WIN_LOW_MAX, WIN_LOW_MIN));
    c_hi = ($urandom_range(99) < 15) ? CAL_W'($urandom) :
           CAL_W'($urandom_range(WIN_HIGH_MAX, WIN_HIGH_MIN));
    apply_setting(lo, hi, {17'($urandom), c_lo}, {17'($urandom), c_hi});
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers at their reset values: uncalibrated and an empty range.
    send_word(32'h0, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'd5, 1'b1);
    finish_phase();

    // Nominal calibration, range edges, clamping and fault.
    apply_setting(32'd1000, 32'd5000, 32'd4096, 32'd20480);
    send_word(32'd0, 1'b0);
    send_word(32'd999, 1'b0);
    send_word(32'd1000, 1'b0);
    send_word(32'd3000, 1'b0);
    send_word(32'd5000, 1'b0);
    send_word(32'd5001, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'd0, 1'b1);
    send_word(32'd3000, 1'b1);
    finish_phase();

    // Full range with the outer window edges.
    apply_setting(32'h0, 32'hFFFF_FFFF, 32'd3584, 32'd21504);
    send_word(32'h0, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h1234_5678, 1'b1);
    finish_phase();

    // Inverted range with the inner window edges; fault saturates high.
    apply_setting(32'd7000, 32'd100, 32'd4608, 32'd19456);
    send_word(32'd50, 1'b0);
    send_word(32'd500, 1'b0);
    send_word(32'd9000, 1'b0);
    send_word(32'd500, 1'b1);
    finish_phase();

    // Both currents just outside their windows, upper register bits set.
    apply_setting(32'd0, 32'd1000, 32'hFFFF_8000 | 32'd3583, 32'hAAAA_8000 | 32'd21505);
    send_word(32'd500, 1'b0);
    send_word(32'd500, 1'b1);
    finish_phase();

    // Only the high current outside its window.
    apply_setting(32'd0, 32'd1000, 32'd4096, 32'd19455);
    send_word(32'd1000, 1'b0);
    finish_phase();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      random_setting();
      src_idle_pct = (ph == 1 || ph == 2) ? 0 : 20;
      sink_idle_pct = (ph == 1) ? 0 : 20;
      if (ph == 2) hold_start = 1'b1;
      for (int n = 0; n < WORDS_PER_PHASE; n++)
        send_word(pick_level(board.range_lo, board.range_hi), $urandom_range(7) == 0);
      finish_phase();
    end

    repeat (50) @(posedge clk);
    board.errors += board.pending();
    $display("tb: %0d words checked over %0d register settings, %0d with fault",
             board.checked, settings, board.n_fault);
    $display("tb: results seen: %0d clamped, %0d saturated, %0d uncalibrated",
             board.n_clamped, board.n_sat, board.n_uncal);
    if (board.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule

// File: sim.f
hdl/cldac_pkg.sv
hdl/cldac_front.sv
hdl/cldac_tdiv.sv
hdl/cldac_code.sv
hdl/cldac_oreg.sv
hdl/current_loop_dac_scaler.sv
dv/tb.sv
